@@ hdl/round_robin_pairing_generator_defines.svh @@
// Assertion macros shared by the round-robin pairing generator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ROUND_ROBIN_PAIRING_GENERATOR_DEFINES_SVH
`define ROUND_ROBIN_PAIRING_GENERATOR_DEFINES_SVH

`ifndef SYNTH

// Assertion checked only while reset is released.
`define RRPG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrpg assertion failed");

// Assertion checked on every clock edge, during reset as well.
`define RRPG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rrpg assertion failed");

`else

`define RRPG_ASSERT(lbl, clk, rst_n, prop)
`define RRPG_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hdl/rrpg_pkg.sv @@
// Types and constants for the round-robin pairing generator.
// Depends on nothing; used by rrpg_ring_map and the top level.
package rrpg_pkg;

    // Team count width: holds counts up to 127.
    localparam int CNT_W = 7;
    // Ring index, pair counter and rotation count width.
    localparam int IDX_W = 6;
    // Field widths of the result items.
    localparam int TEAM_W = 5;
    localparam int PAIR_W = 4;
    // Width of the num_teams register.
    localparam int CFG_W = 6;
    // Smallest team count that the schedule supports.
    localparam int MIN_TEAMS = 2;

    // Round geometry shared by the ring mappers.
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] half;
    } ring_cfg_t;

endpackage

@@ hdl/round_robin_pairing_generator.sv @@
// Round-robin pairing generator (circle method), top level.
// A taken item sets the run state, then the first pair is loaded into the output register.
// A round of n teams gives floor(n/2) pairs, one a cycle while the output slot is free;
// the block takes the next item only once the last pair is loaded and it is idle again.
// Reset (synchronous, aresetn low): two teams, identity order, no result pending.
// The order is kept as a rotation count on the circle of positions 1..n-1, not as a table.
`include "round_robin_pairing_generator_defines.svh"

module round_robin_pairing_generator #(
    parameter int MAX_TEAMS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write channel (num_teams).
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrpg_pkg::CFG_W-1:0]    cfg_data,
    // Round request channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    // Pair result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rrpg_pkg::TEAM_W-1:0]   m_team_a,
    output logic [rrpg_pkg::TEAM_W-1:0]   m_team_b,
    output logic [rrpg_pkg::PAIR_W-1:0]   m_pair_index,
    output logic                          m_last_pair
);

    localparam int CNT_W = rrpg_pkg::CNT_W;
    localparam int IDX_W = rrpg_pkg::IDX_W;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_TEAMS);
    localparam logic [CNT_W-1:0] MIN_N = CNT_W'(rrpg_pkg::MIN_TEAMS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                        state_reg, state_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [CNT_W-1:0]            half_reg, half_next;
    logic [CNT_W-1:0]            ring_len_reg, ring_len_next;
    logic [IDX_W-1:0]            rot_reg, rot_next;
    logic [IDX_W-1:0]            pair_reg, pair_next;
    logic [IDX_W-1:0]            ka_reg, ka_next;
    logic [IDX_W-1:0]            kb_reg, kb_next;
    logic                        m_valid_reg, m_valid_next;
    logic [rrpg_pkg::TEAM_W-1:0] team_a_reg, team_b_reg;
    logic [rrpg_pkg::PAIR_W-1:0] pair_index_reg;
    logic                        last_pair_reg;

    rrpg_pkg::ring_cfg_t         ring_cfg;
    logic [rrpg_pkg::TEAM_W-1:0] team_a_map, team_b_map;
    logic [CNT_W-1:0]            cfg_ext, cfg_n;
    logic [IDX_W-1:0]            ring_last;
    logic [IDX_W-1:0]            rot_start, k_start, rot_step, ka_step, kb_step;
    logic                        in_take, cfg_take, out_load, round_last;

    // A configuration write has priority, so a round request waits while one is offered.
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_take   = s_valid && s_ready;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);

    assign ring_cfg.n    = n_reg;
    assign ring_cfg.half = half_reg;

    // Team lookups for the top-row and bottom-row members of the current pair.
    rrpg_ring_map u_map_a (
        .cfg      (ring_cfg),
        .ring_idx (ka_reg),
        .team     (team_a_map)
    );

    rrpg_ring_map u_map_b (
        .cfg      (ring_cfg),
        .ring_idx (kb_reg),
        .team     (team_b_map)
    );

    // Modular steps on the circle and the clamped team count of a write.
    always_comb begin
        ring_last  = IDX_W'(ring_len_reg - CNT_W'(1));
        rot_start  = s_restart ? '0 : rot_reg;
        k_start    = (rot_start == '0) ? '0 : IDX_W'(ring_len_reg - CNT_W'(rot_start));
        rot_step   = (rot_reg == ring_last) ? '0 : rot_reg + IDX_W'(1);
        ka_step    = (ka_reg == '0) ? ring_last : ka_reg - IDX_W'(1);
        kb_step    = (kb_reg == ring_last) ? '0 : kb_reg + IDX_W'(1);
        round_last = (CNT_W'(pair_reg) == half_reg - CNT_W'(1));

        cfg_ext = CNT_W'(cfg_data);
        if (cfg_ext < MIN_N) begin
            cfg_n = MIN_N;
        end else if (cfg_ext > MAX_N) begin
            cfg_n = MAX_N;
        end else begin
            cfg_n = cfg_ext;
        end
    end

    // Sequencer: one pair a cycle while the output slot is free.
    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        half_next     = half_reg;
        ring_len_next = ring_len_reg;
        rot_next      = rot_reg;
        pair_next     = pair_reg;
        ka_next       = ka_reg;
        kb_next       = kb_reg;
        m_valid_next  = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_take) begin
            n_next        = cfg_n;
            half_next     = cfg_n >> 1;
            ring_len_next = cfg_n - CNT_W'(1);
            rot_next      = '0;
        end else if (in_take) begin
            state_next = ST_RUN;
            rot_next   = rot_start;
            pair_next  = '0;
            ka_next    = k_start;
            kb_next    = k_start;
        end else if (out_load) begin
            m_valid_next = 1'b1;
            pair_next    = pair_reg + IDX_W'(1);
            ka_next      = ka_step;
            kb_next      = kb_step;
            if (round_last) begin
                state_next = ST_IDLE;
                rot_next   = rot_step;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            n_reg        <= MIN_N;
            half_reg     <= MIN_N >> 1;
            ring_len_reg <= MIN_N - CNT_W'(1);
            rot_reg      <= '0;
            pair_reg     <= '0;
            ka_reg       <= '0;
            kb_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            half_reg     <= half_next;
            ring_len_reg <= ring_len_next;
            rot_reg      <= rot_next;
            pair_reg     <= pair_next;
            ka_reg       <= ka_next;
            kb_reg       <= kb_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Output item register; position 0 never moves, so team 0 leads pair 0.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            team_a_reg     <= (pair_reg == '0) ? '0 : team_a_map;
            team_b_reg     <= team_b_map;
            pair_index_reg <= pair_reg[rrpg_pkg::PAIR_W-1:0];
            last_pair_reg  <= round_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_team_a     = team_a_reg;
    assign m_team_b     = team_b_reg;
    assign m_pair_index = pair_index_reg;
    assign m_last_pair  = last_pair_reg;

    // The rotation count always stays inside the circle.
    `RRPG_ASSERT(a_rot_in_ring, aclk, aresetn, rot_reg < IDX_W'(ring_len_reg))
    // Ring indices stay inside the circle while a round runs.
    `RRPG_ASSERT(a_ka_in_ring, aclk, aresetn, (state_reg == ST_RUN) |-> (ka_reg < IDX_W'(ring_len_reg)))
    `RRPG_ASSERT(a_kb_in_ring, aclk, aresetn, (state_reg == ST_RUN) |-> (kb_reg < IDX_W'(ring_len_reg)))
    // The pair counter never passes the end of the round.
    `RRPG_ASSERT(a_pair_in_round, aclk, aresetn, (state_reg == ST_RUN) |-> (CNT_W'(pair_reg) < half_reg))
    // A pending pair that is not the last one means the round is still running.
    `RRPG_ASSERT(a_round_open, aclk, aresetn, (m_valid_reg && !last_pair_reg) |-> (state_reg == ST_RUN))
    // A taken item starts a round in the next cycle.
    `RRPG_ASSERT(a_take_starts, aclk, aresetn, in_take |=> (state_reg == ST_RUN))

endmodule

@@ hdl/rrpg_ring_map.sv @@
// Maps a ring index of the rotating circle to the team number found there.
// Depends on rrpg_pkg.
module rrpg_ring_map (
    input  rrpg_pkg::ring_cfg_t         cfg,
    input  logic [rrpg_pkg::IDX_W-1:0]  ring_idx,
    output logic [rrpg_pkg::TEAM_W-1:0] team
);

    logic [rrpg_pkg::CNT_W-1:0] idx_ext;
    logic [rrpg_pkg::CNT_W-1:0] bottom_len;
    logic [rrpg_pkg::CNT_W-1:0] team_full;

    // The ring runs along the bottom row left to right, then back along the
    // top row right to left. Positions hold the identity before any rotation.
    always_comb begin
        idx_ext    = rrpg_pkg::CNT_W'(ring_idx);
        bottom_len = cfg.n - cfg.half;
        if (idx_ext < bottom_len) begin
            team_full = cfg.half + idx_ext;
        end else begin
            team_full = cfg.n - rrpg_pkg::CNT_W'(1) - idx_ext;
        end
        team = team_full[rrpg_pkg::TEAM_W-1:0];
    end

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the round-robin pairing generator (circle method).
// Depends on rrpg_pkg and round_robin_pairing_generator; drives a directed
// table of rounds and team counts, then random phases, checked by a predictor.
module tb_top;

    localparam int TEAM_W    = rrpg_pkg::TEAM_W;
    localparam int PAIR_W    = rrpg_pkg::PAIR_W;
    localparam int CFG_W     = rrpg_pkg::CFG_W;
    localparam int MIN_TEAMS = rrpg_pkg::MIN_TEAMS;

    // Longest run of cycles with no handshake on any channel before giving up.
    localparam int IDLE_LIMIT = 400;
    // Items in the random part.
    localparam int RANDOM_ROUNDS = 110;
    localparam int SEATS = 32;

    typedef struct packed {
        logic [TEAM_W-1:0] team_a;
        logic [TEAM_W-1:0] team_b;
        logic [PAIR_W-1:0] pair_index;
        logic              last_pair;
    } pair_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ROUND
    } row_kind_t;

    // One line of the directed script: a team count write or a round request.
    // For a round, value bit 0 is the restart flag.
    typedef struct packed {
        row_kind_t        kind;
        logic [CFG_W-1:0] value;
        logic             typed;
        pair_t            pair;
    } row_t;

    localparam pair_t NO_PAIR = '0;
    // With two teams every round is team 0 against team 1.
    localparam pair_t LONE_PAIR = '{team_a: 5'd0, team_b: 5'd1, pair_index: 4'd0,
                                    last_pair: 1'b1};

    localparam int SCRIPT_LEN = 26;
    localparam row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        // Straight after reset: two teams.
        '{ROW_ROUND, 6'd0,  1'b1, LONE_PAIR},
        '{ROW_ROUND, 6'd1,  1'b1, LONE_PAIR},
        // Counts below the minimum behave as two teams.
        '{ROW_CFG,   6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b1, LONE_PAIR},
        '{ROW_ROUND, 6'd1,  1'b1, LONE_PAIR},
        '{ROW_CFG,   6'd1,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b1, LONE_PAIR},
        // Three teams: the two moving seats simply swap.
        '{ROW_CFG,   6'd3,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd1,  1'b0, NO_PAIR},
        // All register bits set: clamps to the largest table.
        '{ROW_CFG,   6'd63, 1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd1,  1'b0, NO_PAIR},
        '{ROW_CFG,   6'd32, 1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        // Odd count: the last seat sits out.
        '{ROW_CFG,   6'd5,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd1,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_CFG,   6'd4,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR},
        '{ROW_ROUND, 6'd0,  1'b0, NO_PAIR}
    };

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_restart;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [TEAM_W-1:0]   m_team_a;
    logic [TEAM_W-1:0]   m_team_b;
    logic [PAIR_W-1:0]   m_pair_index;
    logic                m_last_pair;

    // Predicted state of the block.
    logic [CFG_W-1:0]    teams_reg;
    logic [TEAM_W-1:0]   seat [0:SEATS-1];

    pair_t pairs_due [$];
    int    mismatches = 0;
    int    burst_left = 0;

    round_robin_pairing_generator #(
        .MAX_TEAMS (SEATS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_team_a     (m_team_a),
        .m_team_b     (m_team_b),
        .m_pair_index (m_pair_index),
        .m_last_pair  (m_last_pair)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Put every seat back to the team of the same number.
    task automatic seat_identity();
        for (int i = 0; i < SEATS; i++) begin
            seat[i] = TEAM_W'(i);
        end
    endtask

    // Append one predicted pair to the tail of the queue.
    task automatic add_due(input pair_t p);
        pairs_due = {pairs_due, p};
    endtask

    // Work out the pairs of one round, queue them, then turn the circle.
    task automatic plan_round(input logic restart, input logic typed, input pair_t typed_pair);
        int          n;
        int          half;
        int          src;
        logic [TEAM_W-1:0] turned [0:SEATS-1];
        pair_t       p;
        n = int'(teams_reg);
        if (n < MIN_TEAMS) begin
            n = MIN_TEAMS;
        end
        if (n > SEATS) begin
            n = SEATS;
        end
        half = n / 2;
        if (restart) begin
            seat_identity();
        end
        if (typed) begin
            add_due(typed_pair);
        end else begin
            for (int j = 0; j < half; j++) begin
                p.team_a     = seat[j];
                p.team_b     = seat[j + half];
                p.pair_index = PAIR_W'(j);
                p.last_pair  = (j == half - 1);
                add_due(p);
            end
        end
        // Top row moves left, bottom row moves right, seat 0 stays put.
        turned = seat;
        for (int j = 1; j < n; j++) begin
            if (j < half) begin
                src = (j == half - 1) ? n - 1 : j + 1;
            end else if (j == half) begin
                src = (half == 1) ? n - 1 : 1;
            end else begin
                src = j - 1;
            end
            turned[j] = seat[src];
        end
        seat = turned;
    endtask

    // Stop sending and wait until every queued pair has been taken.
    task automatic wait_all_pairs();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pairs_due.size() != 0);
        @(posedge aclk);
    endtask

    // Write the team count while the block is idle.
    task automatic write_teams(input logic [CFG_W-1:0] value);
        wait_all_pairs();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        teams_reg = value;
        seat_identity();
    endtask

    // Offer one round request and hold it until it is taken.
    task automatic send_round(input logic restart, input logic typed, input pair_t typed_pair);
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        plan_round(restart, typed, typed_pair);
    endtask

    // Sender pacing: bursts of items separated by idle gaps.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
        end
    endtask

    // Receiver: a free-running cycle counter sets when a new stall style is drawn at random.
    int rx_cycle = 0;
    int rx_mode = 0;
    int stall_left = 0;
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 128 == 0) begin
            rx_mode <= $urandom_range(0, 2);
        end
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left != 0) begin
                    m_ready    <= 1'b0;
                    stall_left <= stall_left - 1;
                end else if ($urandom_range(0, 15) == 0) begin
                    m_ready    <= 1'b0;
                    stall_left <= $urandom_range(1, 11);
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // Compare each pair taken from the block with the oldest prediction.
    always @(posedge aclk) begin
        pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pairs_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pair: expected none, actual %0d %0d %0d %0d",
                         $time, m_team_a, m_team_b, m_pair_index, m_last_pair);
            end else begin
                want = pairs_due.pop_front();
                if (m_team_a !== want.team_a || m_team_b !== want.team_b ||
                    m_pair_index !== want.pair_index || m_last_pair !== want.last_pair) begin
                    mismatches++;
                    $display("%0t: pair mismatch: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                             $time, want.team_a, want.team_b, want.pair_index, want.last_pair,
                             m_team_a, m_team_b, m_pair_index, m_last_pair);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: directed script, then random phases of team counts.
    initial begin
        int          sent;
        int          phase_len;
        int          pick;
        logic [CFG_W-1:0] count;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_restart <= 1'b0;
        teams_reg = CFG_W'(MIN_TEAMS);
        seat_identity();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst_left = 3;
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (SCRIPT[r].kind == ROW_CFG) begin
                write_teams(SCRIPT[r].value);
            end else begin
                send_round(SCRIPT[r].value[0], SCRIPT[r].typed, SCRIPT[r].pair);
                pace();
            end
        end

        // Random phases: mostly continuing calendars, now and then a restart.
        sent = 0;
        while (sent < RANDOM_ROUNDS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                count = CFG_W'($urandom_range(0, 1));
            end else if (pick == 1) begin
                count = CFG_W'($urandom_range(33, 63));
            end else begin
                count = CFG_W'($urandom_range(2, 32));
            end
            write_teams(count);
            phase_len = $urandom_range(6, 30);
            for (int k = 0; k < phase_len && sent < RANDOM_ROUNDS; k++) begin
                send_round($urandom_range(0, 9) == 0, 1'b0, NO_PAIR);
                sent++;
                if ($urandom_range(0, 15) == 0) begin
                    wait_all_pairs();
                end else begin
                    pace();
                end
            end
        end

        wait_all_pairs();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pairs_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
